>>> hdl/sxrb_pkg.sv
package sxrb_pkg;

  // Storage geometry
  localparam int unsigned RegCount  = 64;
  localparam int unsigned RegAw     = $clog2(RegCount);
  localparam int unsigned VramBytes = 1048576;
  localparam int unsigned VramAw    = $clog2(VramBytes);
  // Bank times 128K plus a 17-bit offset, wide enough for the largest memory
  localparam int unsigned SumW      = (VramAw > 21) ? VramAw : 21;

  // Fixed field widths
  localparam int unsigned AddrW  = 20;
  localparam int unsigned ClockW = 27;

  // Request kinds
  typedef enum logic [1:0] {
    KindIndexWr = 2'd0,
    KindDataWr  = 2'd1,
    KindDataRd  = 2'd2,
    KindMemXlat = 2'd3
  } kind_e;

  // Sequencer states
  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

  // Configuration register indexes
  localparam logic [1:0] CfgChipRev   = 2'd0;
  localparam logic [1:0] CfgMiscClock = 2'd1;

  // Extended register indexes with special handling
  localparam logic [RegAw-1:0] RegDipSw    = 6'h20;
  localparam logic [RegAw-1:0] RegCrtHigh  = 6'h23;
  localparam logic [RegAw-1:0] RegMisc26   = 6'h26;
  localparam logic [RegAw-1:0] RegLineHi   = 6'h28;
  localparam logic [RegAw-1:0] RegLineLo   = 6'h29;
  localparam logic [RegAw-1:0] RegChipRev  = 6'h2a;
  localparam logic [RegAw-1:0] RegMisc2b   = 6'h2b;
  localparam logic [RegAw-1:0] RegHtotal   = 6'h2d;
  localparam logic [RegAw-1:0] RegBankAux  = 6'h2e;
  localparam logic [RegAw-1:0] RegMode30   = 6'h30;
  localparam logic [RegAw-1:0] RegMisc31   = 6'h31;
  localparam logic [RegAw-1:0] RegBank     = 6'h32;
  localparam logic [RegAw-1:0] RegEeprom   = 6'h33;
  localparam logic [RegAw-1:0] RegEepromIn = 6'h37;
  localparam logic [RegAw-1:0] RegClkDiv   = 6'h38;
  localparam logic [RegAw-1:0] RegClkSel   = 6'h39;
  localparam logic [RegAw-1:0] RegMisc3a   = 6'h3a;
  localparam logic [RegAw-1:0] RegZero3c   = 6'h3c;
  localparam logic [RegAw-1:0] RegMem3d    = 6'h3d;
  localparam logic [RegAw-1:0] RegMode3e   = 6'h3e;
  localparam logic [RegAw-1:0] RegMisc3f   = 6'h3f;

  localparam logic [7:0] DipSwValue = 8'h10;
  localparam logic [7:0] IdleRead   = 8'hff;

  // Dot clock source frequency in Hz
  function automatic logic [ClockW-1:0] clock_hz(input logic [3:0] sel);
    logic [ClockW-1:0] hz;
    unique case (sel)
      4'd0:    hz = 27'd42954545;
      4'd1:    hz = 27'd48771000;
      4'd2:    hz = 27'd16657000;
      4'd3:    hz = 27'd36000000;
      4'd4:    hz = 27'd50350000;
      4'd5:    hz = 27'd56640000;
      4'd6:    hz = 27'd28322000;
      4'd7:    hz = 27'd44900000;
      4'd8:    hz = 27'd30240000;
      4'd9:    hz = 27'd32000000;
      4'd10:   hz = 27'd37500000;
      4'd11:   hz = 27'd39000000;
      4'd12:   hz = 27'd40000000;
      4'd13:   hz = 27'd56644000;
      4'd14:   hz = 27'd75000000;
      default: hz = 27'd65000000;
    endcase
    return hz;
  endfunction

endpackage

>>> hdl/svga_extended_register_bank_unit.sv
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+---------------------------------
// request   | in        | start high, busy low          | kind_i .. eeprom_in_i
// result    | out       | result_valid_o, one cycle     | read_data_o .. eeprom_update_o
// config    | in        | cfg_valid_i and cfg_ready_o   | cfg_index_i, cfg_data_i
//
// For each request, the accept edge issues the register memory read, the execute
// cycle modifies and writes back, and the result strobes in the cycle after, while
// the next request can already be accepted.
// The 64-entry register memory reads as zero until an entry is written (per-entry
// valid bits), so reset needs no clearing pass; reset is asynchronous, active low.
// The receiver cannot stall; config is always ready.
module svga_extended_register_bank_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   write_value_i,
  input  logic                         port_select_i,
  input  logic [16:0]                  mem_offset_i,
  input  logic                         mem_is_write_i,
  input  logic [9:0]                   line_position_i,
  input  logic                         eeprom_in_i,
  // result channel
  output logic                         result_valid_o,
  output logic [7:0]                   read_data_o,
  output logic [sxrb_pkg::AddrW-1:0]   vram_address_o,
  output logic                         banked_access_o,
  output logic                         rgb8_enable_o,
  output logic [sxrb_pkg::ClockW-1:0]  dot_clock_hz_o,
  output logic [2:0]                   clock_divider_o,
  output logic [1:0]                   pitch_shift_o,
  output logic [1:0]                   start_addr_high_o,
  output logic [1:0]                   cursor_addr_high_o,
  output logic [1:0]                   htotal_update_o,
  output logic [2:0]                   eeprom_pins_o,
  output logic                         eeprom_update_o,
  // configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  localparam int unsigned Aw = sxrb_pkg::RegAw;

  // Control state
  sxrb_pkg::state_e state_q, state_d;
  logic             accept;

  // Latched request
  sxrb_pkg::kind_e  kind_q;
  logic [7:0]       wval_q;
  logic             port_q;
  logic [16:0]      offset_q;
  logic             is_wr_q;
  logic [9:0]       line_q;
  logic             ein_q;

  // Register memory and per-entry valid bits
  logic [7:0]                  mem_q [sxrb_pkg::RegCount];
  logic [sxrb_pkg::RegCount-1:0] vld_q;
  logic [7:0]                  rdata_q;
  logic                        rvld_q;

  // Bank state and shadows of registers that drive outputs every request
  logic [Aw-1:0] index_q, index_d;
  logic [7:0]    chip_rev_q;
  logic [1:0]    misc_clk_q;
  logic [3:0]    rd_bank_q, rd_bank_d, wr_bank_q, wr_bank_d;
  logic [1:0]    start_hi_q, start_hi_d, cursor_hi_q, cursor_hi_d;
  logic [7:0]    r30_q, r30_d, r33_q, r33_d, r38_q, r38_d, r39_q, r39_d;
  logic [7:0]    r32_q, r32_d, r3d_q, r3d_d, r3e_q, r3e_d;

  // Execute-cycle signals
  logic          do_wr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;
  logic [1:0]    htu;
  logic [2:0]    pins;
  logic          pupd;
  logic          rgb8;
  logic [3:0]    bank;

  assign accept      = start && !busy;
  assign busy        = (state_q != sxrb_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  // Sequencer
  always_comb begin
    unique case (state_q)
      sxrb_pkg::StIdle: state_d = accept ? sxrb_pkg::StExec : sxrb_pkg::StIdle;
      sxrb_pkg::StExec: state_d = sxrb_pkg::StIdle;
      default:          state_d = sxrb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sxrb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= sxrb_pkg::kind_e'(kind_i);
      wval_q   <= write_value_i;
      port_q   <= port_select_i;
      offset_q <= mem_offset_i;
      is_wr_q  <= mem_is_write_i;
      line_q   <= line_position_i;
      ein_q    <= eeprom_in_i;
    end
  end

  // Register memory: read at accept, write back at the end of execute
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[index_q];
    end
    if (do_wr) begin
      mem_q[index_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (accept) begin
        rvld_q <= vld_q[index_q];
      end
      if (do_wr) begin
        vld_q[index_q] <= 1'b1;
      end
    end
  end

  // Masked write value and write side effects
  always_comb begin
    do_wr       = (state_q == sxrb_pkg::StExec) && (kind_q == sxrb_pkg::KindDataWr);
    index_d     = index_q;
    wr_data     = wval_q;
    start_hi_d  = start_hi_q;
    cursor_hi_d = cursor_hi_q;
    htu         = 2'd0;
    pins        = 3'd0;
    pupd        = 1'b0;
    if ((state_q == sxrb_pkg::StExec) && (kind_q == sxrb_pkg::KindIndexWr)) begin
      index_d = wval_q[Aw-1:0];
    end
    unique case (index_q)
      sxrb_pkg::RegCrtHigh: begin
        wr_data = wval_q & 8'h1f;
        if (do_wr) begin
          start_hi_d  = {start_hi_q[1], wval_q[4]};
          cursor_hi_d = {wval_q[3], cursor_hi_q[0]};
        end
      end
      sxrb_pkg::RegMisc26: wr_data = wval_q & 8'hc9;
      sxrb_pkg::RegMisc2b: wr_data = wval_q & 8'hdf;
      sxrb_pkg::RegHtotal: begin
        if (do_wr && wval_q[3]) begin
          htu = {1'b0, wval_q[0]} + 2'd1;
        end
      end
      sxrb_pkg::RegMode30: begin
        wr_data = wval_q & 8'h7d;
        if (do_wr) begin
          start_hi_d  = {wval_q[6], start_hi_q[0]};
          cursor_hi_d = {cursor_hi_q[1], wval_q[2]};
        end
      end
      sxrb_pkg::RegMisc31: wr_data = wval_q & 8'h7f;
      sxrb_pkg::RegEeprom: begin
        wr_data = wval_q & 8'hef;
        if (do_wr && wval_q[2]) begin
          pins = {wval_q[3], wval_q[1], wval_q[0]};
          pupd = 1'b1;
        end
      end
      sxrb_pkg::RegClkDiv: wr_data = wval_q & 8'hef;
      sxrb_pkg::RegClkSel: wr_data = wval_q & 8'hfe;
      sxrb_pkg::RegMisc3a: wr_data = wval_q & 8'h07;
      sxrb_pkg::RegZero3c: wr_data = 8'h00;
      sxrb_pkg::RegMem3d:  wr_data = wval_q & 8'hfd;
      sxrb_pkg::RegMode3e: wr_data = wval_q & 8'h1f;
      sxrb_pkg::RegMisc3f: wr_data = wval_q & 8'h0f;
      default: ;
    endcase
  end

  // Shadow updates, taken after the write so outputs see the new values
  always_comb begin
    r30_d = (do_wr && index_q == sxrb_pkg::RegMode30) ? wr_data : r30_q;
    r32_d = (do_wr && index_q == sxrb_pkg::RegBank)   ? wr_data : r32_q;
    r33_d = (do_wr && index_q == sxrb_pkg::RegEeprom) ? wr_data : r33_q;
    r38_d = (do_wr && index_q == sxrb_pkg::RegClkDiv) ? wr_data : r38_q;
    r39_d = (do_wr && index_q == sxrb_pkg::RegClkSel) ? wr_data : r39_q;
    r3d_d = (do_wr && index_q == sxrb_pkg::RegMem3d)  ? wr_data : r3d_q;
    r3e_d = (do_wr && index_q == sxrb_pkg::RegMode3e) ? wr_data : r3e_q;
    rd_bank_d = rd_bank_q;
    wr_bank_d = wr_bank_q;
    if (do_wr && (index_q == sxrb_pkg::RegBankAux || index_q == sxrb_pkg::RegBank ||
                  index_q == sxrb_pkg::RegMode3e)) begin
      if (r3e_d[3]) begin
        // split mode: separate read and write banks
        rd_bank_d = {r32_d[0], r32_d[7:5]};
        wr_bank_d = r32_d[4:1];
      end else begin
        rd_bank_d = r32_d[4:1];
        wr_bank_d = r32_d[4:1];
      end
    end
  end

  // Data port reads
  always_comb begin
    rd_data = sxrb_pkg::IdleRead;
    if (kind_q == sxrb_pkg::KindDataRd && port_q) begin
      unique case (index_q)
        sxrb_pkg::RegDipSw:    rd_data = sxrb_pkg::DipSwValue;
        sxrb_pkg::RegLineHi:   rd_data = {6'd0, line_q[9:8]};
        sxrb_pkg::RegLineLo:   rd_data = line_q[7:0];
        sxrb_pkg::RegChipRev:  rd_data = chip_rev_q;
        sxrb_pkg::RegEepromIn: rd_data = {4'd0, ein_q, 3'd0};
        sxrb_pkg::RegMem3d:    rd_data = {4'h1, r3d_q[3:0]};
        default:               rd_data = rvld_q ? rdata_q : 8'h00;
      endcase
    end
  end

  // Banked address translation
  logic [sxrb_pkg::SumW-1:0] addr_sum;
  logic [sxrb_pkg::SumW-1:0] addr_mod;
  assign rgb8 = r30_d[5];
  assign bank = is_wr_q ? wr_bank_d : rd_bank_d;
  always_comb begin
    if (r3d_d[2]) begin
      addr_sum = sxrb_pkg::SumW'({bank, offset_q});
    end else begin
      addr_sum = sxrb_pkg::SumW'({bank, offset_q[15:0]});
    end
    addr_mod = addr_sum & sxrb_pkg::SumW'(sxrb_pkg::VramBytes - 1);
  end

  // Control and shadow registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= '0;
      chip_rev_q  <= 8'd6;
      misc_clk_q  <= 2'd0;
      rd_bank_q   <= 4'd0;
      wr_bank_q   <= 4'd0;
      start_hi_q  <= 2'd0;
      cursor_hi_q <= 2'd0;
      r30_q       <= 8'd0;
      r32_q       <= 8'd0;
      r33_q       <= 8'd0;
      r38_q       <= 8'd0;
      r39_q       <= 8'd0;
      r3d_q       <= 8'd0;
      r3e_q       <= 8'd0;
      result_valid_o <= 1'b0;
    end else begin
      index_q     <= index_d;
      rd_bank_q   <= rd_bank_d;
      wr_bank_q   <= wr_bank_d;
      start_hi_q  <= start_hi_d;
      cursor_hi_q <= cursor_hi_d;
      r30_q       <= r30_d;
      r32_q       <= r32_d;
      r33_q       <= r33_d;
      r38_q       <= r38_d;
      r39_q       <= r39_d;
      r3d_q       <= r3d_d;
      r3e_q       <= r3e_d;
      result_valid_o <= (state_q == sxrb_pkg::StExec);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == sxrb_pkg::CfgChipRev) begin
          chip_rev_q <= cfg_data_i;
        end else if (cfg_index_i == sxrb_pkg::CfgMiscClock) begin
          misc_clk_q <= cfg_data_i[1:0];
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (state_q == sxrb_pkg::StExec) begin
      read_data_o        <= rd_data;
      banked_access_o    <= (kind_q == sxrb_pkg::KindMemXlat) && rgb8;
      vram_address_o     <= ((kind_q == sxrb_pkg::KindMemXlat) && rgb8) ?
                            addr_mod[sxrb_pkg::AddrW-1:0] : '0;
      rgb8_enable_o      <= rgb8;
      dot_clock_hz_o     <= sxrb_pkg::clock_hz({r3e_d[4], r39_d[1], misc_clk_q});
      clock_divider_o    <= {1'b0, r38_d[7:6]} + 3'd1;
      pitch_shift_o      <= rgb8 ? 2'd3 : (r33_d[6] ? 2'd2 : 2'd0);
      start_addr_high_o  <= start_hi_d;
      cursor_addr_high_o <= cursor_hi_d;
      htotal_update_o    <= htu;
      eeprom_pins_o      <= pins;
      eeprom_update_o    <= pupd;
    end
  end

  // Checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sxrb_pkg::StExec))
    else $error("accepted request did not enter execute");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sxrb_pkg::StExec) |=> (result_valid_o && !busy))
    else $error("execute cycle did not produce exactly one result");

  a_joint_banks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!r3e_q[3] && $past(do_wr) && $past(index_q == sxrb_pkg::RegBank))
      |-> (rd_bank_q == wr_bank_q))
    else $error("joint mode banks differ after bank write");

  a_banked_rgb8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && banked_access_o) |-> rgb8_enable_o)
    else $error("banked access without packed 256-color mode");

endmodule

>>> tb/svga_extended_register_bank_unit_test.sv
module svga_extended_register_bank_unit_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned PhaseItems = 155;

  // Horizontal total bit 8 update codes
  localparam logic [1:0] HtNoChange = 2'd0;
  localparam logic [1:0] HtClear    = 2'd1;
  localparam logic [1:0] HtSet      = 2'd2;

  // One host access as the driver presents it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  wdata;
    logic        port_sel;
    logic [16:0] offset;
    logic        is_wr;
    logic [9:0]  line;
    logic        ein;
    logic        drain_first;
  } host_access_t;

  // One result of the bank
  typedef struct packed {
    logic [7:0]                  read_data;
    logic [sxrb_pkg::AddrW-1:0]  vram_address;
    logic                        banked;
    logic                        rgb8;
    logic [sxrb_pkg::ClockW-1:0] dot_clock;
    logic [2:0]                  divider;
    logic [1:0]                  pitch;
    logic [1:0]                  start_high;
    logic [1:0]                  cursor_high;
    logic [1:0]                  htotal;
    logic [2:0]                  pins;
    logic                        pins_update;
  } bank_response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = 2'd0;
  logic [7:0]  write_value_i = 8'd0;
  logic        port_select_i = 1'b0;
  logic [16:0] mem_offset_i = 17'd0;
  logic        mem_is_write_i = 1'b0;
  logic [9:0]  line_position_i = 10'd0;
  logic        eeprom_in_i = 1'b0;

  logic                        result_valid_o;
  logic [7:0]                  read_data_o;
  logic [sxrb_pkg::AddrW-1:0]  vram_address_o;
  logic                        banked_access_o;
  logic                        rgb8_enable_o;
  logic [sxrb_pkg::ClockW-1:0] dot_clock_hz_o;
  logic [2:0]                  clock_divider_o;
  logic [1:0]                  pitch_shift_o;
  logic [1:0]                  start_addr_high_o;
  logic [1:0]                  cursor_addr_high_o;
  logic [1:0]                  htotal_update_o;
  logic [2:0]                  eeprom_pins_o;
  logic                        eeprom_update_o;

  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = 2'd0;
  logic [7:0] cfg_data_i = 8'd0;

  svga_extended_register_bank_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .write_value_i      (write_value_i),
    .port_select_i      (port_select_i),
    .mem_offset_i       (mem_offset_i),
    .mem_is_write_i     (mem_is_write_i),
    .line_position_i    (line_position_i),
    .eeprom_in_i        (eeprom_in_i),
    .result_valid_o     (result_valid_o),
    .read_data_o        (read_data_o),
    .vram_address_o     (vram_address_o),
    .banked_access_o    (banked_access_o),
    .rgb8_enable_o      (rgb8_enable_o),
    .dot_clock_hz_o     (dot_clock_hz_o),
    .clock_divider_o    (clock_divider_o),
    .pitch_shift_o      (pitch_shift_o),
    .start_addr_high_o  (start_addr_high_o),
    .cursor_addr_high_o (cursor_addr_high_o),
    .htotal_update_o    (htotal_update_o),
    .eeprom_pins_o      (eeprom_pins_o),
    .eeprom_update_o    (eeprom_update_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the bank state and configuration
  logic [7:0] shadow_regs [sxrb_pkg::RegCount];
  logic [5:0] shadow_index;
  logic [3:0] shadow_rd_bank;
  logic [3:0] shadow_wr_bank;
  logic [1:0] shadow_start_hi;
  logic [1:0] shadow_cursor_hi;
  logic [7:0] shadow_chip_rev;
  logic [1:0] shadow_misc_clk;

  host_access_t   access_queue[$];
  bank_response_t pending_responses[$];
  host_access_t   cur_access;
  int             burst_left = 0;
  int             gap_left = 0;
  int             mismatches = 0;
  int unsigned    cycles = 0;

  // Source frequency for a dot clock select code
  function automatic logic [sxrb_pkg::ClockW-1:0] source_clock_hz(input logic [3:0] sel);
    case (sel)
      4'd0:    return 27'd42954545;
      4'd1:    return 27'd48771000;
      4'd2:    return 27'd16657000;
      4'd3:    return 27'd36000000;
      4'd4:    return 27'd50350000;
      4'd5:    return 27'd56640000;
      4'd6:    return 27'd28322000;
      4'd7:    return 27'd44900000;
      4'd8:    return 27'd30240000;
      4'd9:    return 27'd32000000;
      4'd10:   return 27'd37500000;
      4'd11:   return 27'd39000000;
      4'd12:   return 27'd40000000;
      4'd13:   return 27'd56644000;
      4'd14:   return 27'd75000000;
      default: return 27'd65000000;
    endcase
  endfunction

  // Apply one accepted request to the shadow state and queue its expected result
  task automatic apply_access(input host_access_t a);
    bank_response_t r;
    logic [5:0]                idx;
    logic [7:0]                d;
    logic [7:0]                v;
    logic [7:0]                b;
    logic [3:0]                bank;
    logic [sxrb_pkg::SumW-1:0] linear_addr;
    r = '0;
    r.read_data = sxrb_pkg::IdleRead;
    r.htotal = HtNoChange;
    idx = shadow_index;
    d = a.wdata;
    case (a.kind)
      sxrb_pkg::KindIndexWr: shadow_index = d[5:0];
      sxrb_pkg::KindDataWr: begin
        v = d;
        case (idx)
          sxrb_pkg::RegCrtHigh: begin
            shadow_start_hi[0] = d[4];
            shadow_cursor_hi[1] = d[3];
            v = d & 8'h1f;
          end
          sxrb_pkg::RegMisc26: v = d & 8'hc9;
          sxrb_pkg::RegMisc2b: v = d & 8'hdf;
          sxrb_pkg::RegHtotal: begin
            if (d[3]) r.htotal = d[0] ? HtSet : HtClear;
          end
          sxrb_pkg::RegMode30: begin
            shadow_start_hi[1] = d[6];
            shadow_cursor_hi[0] = d[2];
            v = d & 8'h7d;
          end
          sxrb_pkg::RegMisc31: v = d & 8'h7f;
          sxrb_pkg::RegEeprom: begin
            v = d & 8'hef;
            if (d[2]) begin
              r.pins = {d[3], d[1], d[0]};
              r.pins_update = 1'b1;
            end
          end
          sxrb_pkg::RegClkDiv: v = d & 8'hef;
          sxrb_pkg::RegClkSel: v = d & 8'hfe;
          sxrb_pkg::RegMisc3a: v = d & 8'h07;
          sxrb_pkg::RegZero3c: v = 8'h00;
          sxrb_pkg::RegMem3d:  v = d & 8'hfd;
          sxrb_pkg::RegMode3e: v = d & 8'h1f;
          sxrb_pkg::RegMisc3f: v = d & 8'h0f;
          default: ;
        endcase
        shadow_regs[idx] = v;
        // bank registers: split mode takes the read bank from the outer bits
        if (idx == sxrb_pkg::RegBankAux || idx == sxrb_pkg::RegBank ||
            idx == sxrb_pkg::RegMode3e) begin
          b = shadow_regs[sxrb_pkg::RegBank];
          if (shadow_regs[sxrb_pkg::RegMode3e][3]) begin
            shadow_rd_bank = {b[0], b[7:5]};
            shadow_wr_bank = b[4:1];
          end else begin
            shadow_rd_bank = b[4:1];
            shadow_wr_bank = b[4:1];
          end
        end
      end
      sxrb_pkg::KindDataRd: begin
        if (a.port_sel) begin
          case (idx)
            sxrb_pkg::RegDipSw:    r.read_data = sxrb_pkg::DipSwValue;
            sxrb_pkg::RegLineHi:   r.read_data = {6'd0, a.line[9:8]};
            sxrb_pkg::RegLineLo:   r.read_data = a.line[7:0];
            sxrb_pkg::RegChipRev:  r.read_data = shadow_chip_rev;
            sxrb_pkg::RegEepromIn: r.read_data = {4'd0, a.ein, 3'd0};
            sxrb_pkg::RegMem3d:    r.read_data = {4'h1, shadow_regs[sxrb_pkg::RegMem3d][3:0]};
            default:               r.read_data = shadow_regs[idx];
          endcase
        end
      end
      default: ;
    endcase

    r.rgb8 = shadow_regs[sxrb_pkg::RegMode30][5];
    // banked window translation, 128K windows when 0x3d bit 2 is set
    if (a.kind == sxrb_pkg::KindMemXlat && r.rgb8) begin
      bank = a.is_wr ? shadow_wr_bank : shadow_rd_bank;
      if (shadow_regs[sxrb_pkg::RegMem3d][2])
        linear_addr = {bank, 17'd0} + a.offset;
      else
        linear_addr = {bank, 16'd0} + a.offset[15:0];
      r.vram_address = sxrb_pkg::AddrW'(linear_addr % sxrb_pkg::VramBytes);
      r.banked = 1'b1;
    end
    r.dot_clock = source_clock_hz({shadow_regs[sxrb_pkg::RegMode3e][4],
                                   shadow_regs[sxrb_pkg::RegClkSel][1], shadow_misc_clk});
    r.divider = {1'b0, shadow_regs[sxrb_pkg::RegClkDiv][7:6]} + 3'd1;
    r.pitch = r.rgb8 ? 2'd3 : (shadow_regs[sxrb_pkg::RegEeprom][6] ? 2'd2 : 2'd0);
    r.start_high = shadow_start_hi;
    r.cursor_high = shadow_cursor_hi;
    pending_responses.push_back(r);
  endtask

  // Request driver: bursts with random gaps, optional drain before an item
  always @(posedge clk_i) begin : request_driver
    logic present;
    if (rst_ni) begin
      present = start;
      if (start && !busy) begin
        apply_access(cur_access);
        present = 1'b0;
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_queue.size() != 0 &&
                     (!access_queue[0].drain_first || pending_responses.size() == 0)) begin
          cur_access = access_queue.pop_front();
          present = 1'b1;
          kind_i <= cur_access.kind;
          write_value_i <= cur_access.wdata;
          port_select_i <= cur_access.port_sel;
          mem_offset_i <= cur_access.offset;
          mem_is_write_i <= cur_access.is_wr;
          line_position_i <= cur_access.line;
          eeprom_in_i <= cur_access.ein;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
          end
        end
      end
      start <= present;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Result monitor: every strobe must match the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    bank_response_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result strobe with no request outstanding");
      end else begin
        want = pending_responses.pop_front();
        check_field("read_data", 32'(want.read_data), 32'(read_data_o));
        check_field("vram_address", 32'(want.vram_address), 32'(vram_address_o));
        check_field("banked_access", 32'(want.banked), 32'(banked_access_o));
        check_field("rgb8_enable", 32'(want.rgb8), 32'(rgb8_enable_o));
        check_field("dot_clock_hz", 32'(want.dot_clock), 32'(dot_clock_hz_o));
        check_field("clock_divider", 32'(want.divider), 32'(clock_divider_o));
        check_field("pitch_shift", 32'(want.pitch), 32'(pitch_shift_o));
        check_field("start_addr_high", 32'(want.start_high), 32'(start_addr_high_o));
        check_field("cursor_addr_high", 32'(want.cursor_high), 32'(cursor_addr_high_o));
        check_field("htotal_update", 32'(want.htotal), 32'(htotal_update_o));
        check_field("eeprom_pins", 32'(want.pins), 32'(eeprom_pins_o));
        check_field("eeprom_update", 32'(want.pins_update), 32'(eeprom_update_o));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[svga_extended_register_bank_unit] ERROR");
    $finish;
  end

  task automatic push_item(input sxrb_pkg::kind_e k, input logic [7:0] wv, input logic port,
                           input logic [16:0] off, input logic isw, input logic [9:0] line,
                           input logic ein, input logic drain);
    host_access_t a;
    a.kind = k;
    a.wdata = wv;
    a.port_sel = port;
    a.offset = off;
    a.is_wr = isw;
    a.line = line;
    a.ein = ein;
    a.drain_first = drain;
    access_queue.push_back(a);
  endtask

  // Request with random offset, direction, line position and EEPROM input
  task automatic push_random(input sxrb_pkg::kind_e k, input logic [7:0] wv,
                             input logic port, input logic drain);
    push_item(k, wv, port, 17'($urandom), 1'($urandom), 10'($urandom), 1'($urandom), drain);
  endtask

  // Wait until nothing is queued, presented or outstanding, then a little longer
  task automatic wait_drained();
    do @(posedge clk_i);
    while (access_queue.size() != 0 || start || pending_responses.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] index, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      sxrb_pkg::CfgChipRev:   shadow_chip_rev = data;
      sxrb_pkg::CfgMiscClock: shadow_misc_clk = data[1:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // Stimulus
  initial begin : stimulus
    int n;
    int sel;
    int ops;
    logic [7:0] chip;
    logic drain;
    logic [16:0] off;

    for (int i = 0; i < sxrb_pkg::RegCount; i++) shadow_regs[i] = 8'h00;
    shadow_index = '0;
    shadow_rd_bank = '0;
    shadow_wr_bank = '0;
    shadow_start_hi = '0;
    shadow_cursor_hi = '0;
    shadow_chip_rev = 8'd6;
    shadow_misc_clk = 2'd0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_config(sxrb_pkg::CfgChipRev, 8'hff);
    write_config(sxrb_pkg::CfgMiscClock, 8'd3);

    // directed: special reads, masked writes, side effects, translation
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'he0, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b1, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h28, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b1, 17'h00000, 1'b0, 10'h3ff, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h2a, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b1, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h37, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b1, 17'h00000, 1'b0, 10'h000, 1'b1, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h23, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'hff, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h2d, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'h09, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h33, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'h4f, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h30, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'hff, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h3e, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'h18, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h32, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'hff, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindMemXlat, 8'h00, 1'b0, 17'h1ffff, 1'b1, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindMemXlat, 8'h00, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindIndexWr, 8'h3d, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataWr,  8'hff, 1'b0, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindDataRd,  8'h00, 1'b1, 17'h00000, 1'b0, 10'h000, 1'b0, 1'b0);
    push_item(sxrb_pkg::KindMemXlat, 8'h00, 1'b0, 17'h1ffff, 1'b0, 10'h000, 1'b0, 1'b0);
    wait_drained();

    // random phases, each under its own configuration
    for (int p = 0; p < PhaseCount; p++) begin
      chip = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom);
      write_config(sxrb_pkg::CfgChipRev, chip);
      write_config(sxrb_pkg::CfgMiscClock, 8'(p % 4));
      n = 0;
      while (n < PhaseItems) begin
        sel = $urandom_range(0, 99);
        drain = ($urandom_range(0, 79) == 0);
        if (sel < 65) begin
          // index write, mostly into the extended range, then a few data accesses
          if ($urandom_range(0, 4) != 0)
            push_random(sxrb_pkg::KindIndexWr, {2'($urandom), 1'b1, 5'($urandom)}, 1'b0,
                        drain);
          else
            push_random(sxrb_pkg::KindIndexWr, 8'($urandom), 1'b0, drain);
          ops = $urandom_range(1, 3);
          for (int k = 0; k < ops; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
              push_random(sxrb_pkg::KindDataWr, random_byte(), 1'($urandom), 1'b0);
            else if (sel < 90)
              push_random(sxrb_pkg::KindDataRd, 8'($urandom), 1'b1, 1'b0);
            else
              push_random(sxrb_pkg::KindDataRd, 8'($urandom), 1'b0, 1'b0);
          end
          n += 1 + ops;
        end else if (sel < 90) begin
          // window translation, with the offset extremes now and then
          sel = $urandom_range(0, 9);
          off = (sel == 0) ? 17'h00000 : (sel == 1) ? 17'h1ffff : 17'($urandom);
          push_item(sxrb_pkg::KindMemXlat, 8'($urandom), 1'($urandom), off, 1'($urandom),
                    10'($urandom), 1'($urandom), drain);
          n++;
        end else begin
          push_random(sxrb_pkg::kind_e'(2'($urandom)), 8'($urandom), 1'($urandom), drain);
          n++;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0)
      $display("[svga_extended_register_bank_unit] OK");
    else
      $display("[svga_extended_register_bank_unit] ERROR");
    $finish;
  end

endmodule
